[hdl/hte_pkg.sv]
`default_nettype none
package hte_pkg;

  // Frame geometry
  localparam int POS_W          = 6;
  localparam int POS_MAX        = 63;
  localparam int TEXT_START     = 3;
  localparam int FRAME_OVERHEAD = 6;
  localparam int MAX_TEXT_DEF   = 31;
  localparam int LEN_OUT_W      = 5;
  localparam int BYTE_W         = 8;
  localparam int PAGE_W         = 2;

  // Configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 1'b1;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'hFF;

  // Controller -> datapath
  typedef struct packed {
    logic start_frame;
    logic take_byte;
    logic emit_item;
  } hte_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic hdr_match;
    logic frame_end;
    logic page_ok;
    logic slot_free;
    logic emit_last;
  } hte_status_t;

endpackage
`default_nettype wire

[hdl/hte_ctrl.sv]
`default_nettype none
module hte_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire hte_pkg::hte_status_t status,
  output hte_pkg::hte_cmd_t     cmd
);
  import hte_pkg::*;

  localparam logic [1:0] ST_HUNT  = 2'd0;
  localparam logic [1:0] ST_FRAME = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_fire;

  assign in_ready = (state != ST_EMIT);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next      = state;
    cmd             = '0;
    case (state)
      ST_HUNT: begin
        if (in_fire && status.hdr_match) begin
          cmd.start_frame = 1'b1;
          state_next      = ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (in_fire) begin
          cmd.take_byte = 1'b1;
          if (status.frame_end) begin
            state_next = status.page_ok ? ST_EMIT : ST_HUNT;
          end
        end
      end
      ST_EMIT: begin
        if (status.slot_free) begin
          cmd.emit_item = 1'b1;
          if (status.emit_last) begin
            state_next = ST_HUNT;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  // frame closing on a known page must start the text run
  a_end_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FRAME && in_valid && status.frame_end && status.page_ok)
    |=> (state == ST_EMIT))
    else $error("closed frame did not start emitting");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_item && status.emit_last) |=> (state == ST_HUNT && in_ready))
    else $error("input not reopened after last item");

  a_no_take_in_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (!cmd.take_byte && !cmd.start_frame && !in_ready))
    else $error("byte taken while emitting");

endmodule
`default_nettype wire

[hdl/hte_datapath.sv]
`default_nettype none
module hte_datapath #(
  parameter int MAX_TEXT = hte_pkg::MAX_TEXT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [hte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hte_pkg::BYTE_W-1:0]    cfg_data,
  input  wire logic [hte_pkg::BYTE_W-1:0]    rx_byte,
  input  wire hte_pkg::hte_cmd_t             cmd,
  output hte_pkg::hte_status_t               status,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [hte_pkg::PAGE_W-1:0]         page_number,
  output logic [hte_pkg::BYTE_W-1:0]         command_code,
  output logic [hte_pkg::BYTE_W-1:0]         text_byte,
  output logic [hte_pkg::LEN_OUT_W-1:0]      text_length,
  output logic                               has_text,
  output logic                               last
);
  import hte_pkg::*;

  localparam int IDX_W = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

  logic [BYTE_W-1:0] header_value;
  logic [BYTE_W-1:0] tail_value;

  logic [POS_W-1:0]  position;
  logic [1:0]        tail_run;
  logic [BYTE_W-1:0] page_hold;
  logic [BYTE_W-1:0] command_hold;
  logic [BYTE_W-1:0] text_mem [MAX_TEXT];

  logic [POS_W-1:0]  frame_len;
  logic [POS_W-1:0]  emit_idx;

  logic [POS_W-1:0]  pos_next;
  logic [POS_W-1:0]  text_off;
  logic              text_wr;
  logic              tail_hit;
  logic [POS_W-1:0]  len_raw;
  logic [POS_W-1:0]  len_clamp;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
      tail_value   <= TAIL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEADER: header_value <= cfg_data;
        REG_TAIL:   tail_value   <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign pos_next  = (position == POS_W'(POS_MAX)) ? position : position + 1'b1;
  assign text_off  = pos_next - POS_W'(TEXT_START);
  assign text_wr   = (pos_next >= POS_W'(TEXT_START)) && (text_off < POS_W'(MAX_TEXT));
  assign tail_hit  = (rx_byte == tail_value);
  assign len_raw   = (pos_next >= POS_W'(FRAME_OVERHEAD))
                   ? pos_next - POS_W'(FRAME_OVERHEAD - 1) : '0;
  assign len_clamp = (len_raw > POS_W'(MAX_TEXT)) ? POS_W'(MAX_TEXT) : len_raw;

  assign status.hdr_match = (rx_byte == header_value);
  assign status.frame_end = tail_hit && (tail_run == 2'd2);
  assign status.page_ok   = (page_hold[BYTE_W-1:PAGE_W] == '0) && (page_hold[PAGE_W-1:0] != '0);
  assign status.slot_free = !out_valid || out_ready;
  assign status.emit_last = (frame_len == '0) || (emit_idx == frame_len - 1'b1);

  // frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      tail_run <= '0;
    end else if (cmd.start_frame) begin
      position <= '0;
      tail_run <= '0;
    end else if (cmd.take_byte) begin
      position <= pos_next;
      if (!tail_hit || status.frame_end) begin
        tail_run <= '0;
      end else begin
        tail_run <= tail_run + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      if (pos_next == POS_W'(1)) begin
        page_hold <= rx_byte;
      end
      if (pos_next == POS_W'(2)) begin
        command_hold <= rx_byte;
      end
      if (status.frame_end) begin
        frame_len <= len_clamp;
      end
    end
  end

  // text store: one write port, one registered read into the output stage
  always_ff @(posedge clk) begin
    if (cmd.take_byte && text_wr) begin
      text_mem[text_off[IDX_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && status.frame_end) begin
      emit_idx <= '0;
    end else if (cmd.emit_item) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_item) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_item) begin
      page_number  <= page_hold[PAGE_W-1:0];
      command_code <= command_hold;
      text_length  <= frame_len[LEN_OUT_W-1:0];
      has_text     <= (frame_len != '0);
      last         <= status.emit_last;
      if (frame_len == '0) begin
        text_byte <= '0;
      end else begin
        text_byte <= text_mem[emit_idx[IDX_W-1:0]];
      end
    end
  end

  a_emit_fills_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_item |=> out_valid)
    else $error("emitted item not presented");

  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_text) |-> (last && text_byte == '0 && text_length == '0))
    else $error("empty-text item malformed");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_byte && !status.frame_end && position != POS_W'(POS_MAX))
    |=> (position == $past(position) + 1'b1))
    else $error("position did not advance");

endmodule
`default_nettype wire

[hdl/header_tail_frame_extractor_unit.sv]
`default_nettype none
// Frame extractor for a byte-serial display link. Bytes arrive one per
// transfer on the input channel. While hunting, every byte that differs
// from header_value (config index 0, reset 0x55) is dropped. A header opens
// a frame: the next byte is the page, the one after it the command, then up
// to MAX_TEXT text bytes are stored. The frame closes on the first three
// consecutive tail_value bytes (config index 1, reset 0xFF), counted from
// the page byte on, so tails in page or command count. Text length is the
// frame length minus 6, clamped to 0..MAX_TEXT and reported in 5 bits. For
// page 1..3 the block issues one output transfer per text byte, or a single
// transfer with has_text low when the text is empty; last marks the final
// one. Other pages give no output. Timing: one input byte per cycle while
// hunting or inside a frame. After a frame for a known page, in_ready stays
// low while the text run drains, one read of the text memory per cycle
// while the output slot is free, that is while out_valid is low or out_ready is high.
// A header inside a frame is plain data. Configuration is written through
// cfg_write/cfg_index/cfg_data and should only change while idle.
module header_tail_frame_extractor_unit #(
  parameter int MAX_TEXT = hte_pkg::MAX_TEXT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config write port
  input  wire logic                          cfg_write,
  input  wire logic [hte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hte_pkg::BYTE_W-1:0]    cfg_data,
  // byte input
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [hte_pkg::BYTE_W-1:0]    rx_byte,
  // text output
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [hte_pkg::PAGE_W-1:0]         page_number,
  output logic [hte_pkg::BYTE_W-1:0]         command_code,
  output logic [hte_pkg::BYTE_W-1:0]         text_byte,
  output logic [hte_pkg::LEN_OUT_W-1:0]      text_length,
  output logic                               has_text,
  output logic                               last
);
  import hte_pkg::*;

  hte_cmd_t    cmd;
  hte_status_t status;

  // sequencing: hunt / frame / emit
  hte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // config, frame counters, text memory and output register
  hte_datapath #(
    .MAX_TEXT (MAX_TEXT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .page_number  (page_number),
    .command_code (command_code),
    .text_byte    (text_byte),
    .text_length  (text_length),
    .has_text     (has_text),
    .last         (last)
  );

endmodule
`default_nettype wire

[test/frame_result_checker.sv]
`timescale 1ns / 1ps
module frame_result_checker #(
  parameter int MAX_TEXT = hte_pkg::MAX_TEXT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [hte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hte_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [hte_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [hte_pkg::PAGE_W-1:0]    page_number,
  input  logic [hte_pkg::BYTE_W-1:0]    command_code,
  input  logic [hte_pkg::BYTE_W-1:0]    text_byte,
  input  logic [hte_pkg::LEN_OUT_W-1:0] text_length,
  input  logic                          has_text,
  input  logic                          last,
  output int                            fail_count,
  output int                            pending,
  output logic                          mid_frame
);
  import hte_pkg::*;

  typedef struct packed {
    logic [PAGE_W-1:0]    page;
    logic [BYTE_W-1:0]    cmd;
    logic [BYTE_W-1:0]    text;
    logic [LEN_OUT_W-1:0] len;
    logic                 has;
    logic                 fin;
  } text_item_t;

  text_item_t expected_text_q[$];
  text_item_t want, seen;

  // mirrored registers and frame state
  logic [BYTE_W-1:0] hdr_m, tail_m;
  logic              in_frame_m;
  logic [POS_W-1:0]  pos_m;
  logic [1:0]        tails_m;
  logic [BYTE_W-1:0] page_m, cmd_m;
  logic [BYTE_W-1:0] text_m [MAX_TEXT];

  initial begin
    fail_count = 0;
    pending    = 0;
    mid_frame  = 1'b0;
  end

  task automatic predict_frame_byte(input logic [BYTE_W-1:0] b);
    int         flen;
    int         tlen;
    text_item_t it;
    if (!in_frame_m) begin
      if (b == hdr_m) begin
        in_frame_m = 1'b1;
        pos_m      = '0;
        tails_m    = '0;
      end
    end else begin
      if (pos_m < POS_MAX) pos_m = pos_m + 1'b1;
      if (pos_m == 1) page_m = b;
      else if (pos_m == 2) cmd_m = b;
      else if (pos_m >= TEXT_START && pos_m - TEXT_START < MAX_TEXT)
        text_m[pos_m - TEXT_START] = b;

      if (b != tail_m) begin
        tails_m = '0;
      end else if (tails_m < 2) begin
        tails_m = tails_m + 1'b1;
      end else begin
        // third tail in a row closes the frame
        in_frame_m = 1'b0;
        tails_m    = '0;
        flen       = pos_m + 1;
        tlen       = (flen > FRAME_OVERHEAD) ? flen - FRAME_OVERHEAD : 0;
        if (tlen > MAX_TEXT) tlen = MAX_TEXT;
        if (page_m >= 1 && page_m <= 3) begin
          it.page = page_m[PAGE_W-1:0];
          it.cmd  = cmd_m;
          if (tlen == 0) begin
            it.text = '0;
            it.len  = '0;
            it.has  = 1'b0;
            it.fin  = 1'b1;
            expected_text_q.push_back(it);
          end else begin
            for (int i = 0; i < tlen; i++) begin
              it.text = text_m[i];
              it.len  = tlen[LEN_OUT_W-1:0];
              it.has  = 1'b1;
              it.fin  = (i == tlen - 1);
              expected_text_q.push_back(it);
            end
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_text_q.delete();
      hdr_m      = HEADER_RESET;
      tail_m     = TAIL_RESET;
      in_frame_m = 1'b0;
      pos_m      = '0;
      tails_m    = '0;
      page_m     = '0;
      cmd_m      = '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_HEADER) hdr_m = cfg_data;
        else if (cfg_index == REG_TAIL) tail_m = cfg_data;
      end
      // results first: they stem from bytes taken at earlier edges
      if (out_valid && out_ready) begin
        seen = '{page_number, command_code, text_byte, text_length, has_text, last};
        if (expected_text_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing pending: page=%0d cmd=%02h text=%02h",
                     $time, page_number, command_code, text_byte);
          fail_count++;
        end else begin
          want = expected_text_q.pop_front();
          if (want.page != seen.page || want.cmd != seen.cmd || want.text != seen.text ||
              want.len != seen.len || want.has != seen.has || want.fin != seen.fin) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp page=%0d cmd=%02h text=%02h len=%0d has=%0b last=%0b",
                       $time, want.page, want.cmd, want.text, want.len, want.has,
                       want.fin,
                       " / got page=%0d cmd=%02h text=%02h len=%0d has=%0b last=%0b",
                       seen.page, seen.cmd, seen.text, seen.len, seen.has, seen.fin);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_frame_byte(rx_byte);
    end
    pending   <= expected_text_q.size();
    mid_frame <= in_frame_m;
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import hte_pkg::*;

  // longest run of cycles without any transfer before we give up
  localparam int STALL_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER;
  logic [BYTE_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    rx_byte   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PAGE_W-1:0]    page_number;
  logic [BYTE_W-1:0]    command_code;
  logic [BYTE_W-1:0]    text_byte;
  logic [LEN_OUT_W-1:0] text_length;
  logic                 has_text;
  logic                 last;

  int   fail_count;
  int   pending;
  logic mid_frame;

  // idle percentages for each side, moved through three stages by byte count
  int send_idle = 36;
  int recv_idle = 77;
  int sent_bytes = 0;
  int work_bytes = 0;
  int quiet_cycles = 0;

  // the markers currently loaded, so frames can be built to match
  logic [BYTE_W-1:0] cur_header = HEADER_RESET;
  logic [BYTE_W-1:0] cur_tail   = TAIL_RESET;

  header_tail_frame_extractor_unit dut (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .rx_byte,
    .out_valid, .out_ready,
    .page_number, .command_code, .text_byte, .text_length, .has_text, .last
  );

  frame_result_checker checker_i (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .rx_byte,
    .out_valid, .out_ready,
    .page_number, .command_code, .text_byte, .text_length, .has_text, .last,
    .fail_count, .pending, .mid_frame
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver side: one ready decision per edge
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog: a hung handshake on either channel ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // One byte transfer. Called at an edge; returns at the edge where the byte
  // is taken, with valid still high so back-to-back bytes need no toggling.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit counts);
    // stage 1: slow sender, very slow receiver; stage 2 swapped; stage 3 flat out
    if (sent_bytes < 155) begin
      send_idle = 36;
      recv_idle = 77;
    end else if (sent_bytes < 310) begin
      send_idle = 77;
      recv_idle = 36;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
    if (counts) work_bytes++;
  endtask

  // Drop valid and wait for every predicted result to come out, plus the
  // tail of the drain. The first wait lets the checker's count settle.
  task automatic drain;
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Bring the block back to hunting before touching the registers: a frame
  // left open by a broken sequence is closed with tails.
  task automatic settle;
    drain();
    while (mid_frame) begin
      send_byte(cur_tail, 1'b0);
      drain();
    end
  endtask

  task automatic load_markers(input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] t);
    cfg_write <= 1'b1;
    cfg_index <= REG_HEADER;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_TAIL;
    cfg_data  <= t;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    cur_header = h;
    cur_tail   = t;
  endtask

  // One random chunk: mostly well-formed frames with random content, some
  // line noise while hunting, and some frames cut short so that the next
  // chunk lands inside an open frame.
  task automatic send_frame;
    int kind;
    int sz;
    int ntext;
    logic [BYTE_W-1:0] pg;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom_range(255)), 1'b0);
    end else begin
      send_byte(cur_header, 1'b1);
      if (kind < 14) begin
        repeat ($urandom_range(5)) send_byte(BYTE_W'($urandom_range(255)), 1'b1);
      end else begin
        pg = ($urandom_range(99) < 85) ? BYTE_W'($urandom_range(3, 1))
                                       : BYTE_W'($urandom_range(255));
        send_byte(pg, 1'b1);
        send_byte(BYTE_W'($urandom_range(255)), 1'b1);
        // text sizes: mostly short, a few longer up to full, a few past the saturation point
        sz = $urandom_range(99);
        if (sz < 88) ntext = $urandom_range(10);
        else if (sz < 95) ntext = $urandom_range(31, 11);
        else ntext = $urandom_range(70, 32);
        repeat (ntext)
          send_byte(($urandom_range(9) == 0) ? cur_tail : BYTE_W'($urandom_range(255)),
                    1'b1);
        repeat (3) send_byte(cur_tail, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames with the reset markers (header 0x55, tail 0xFF)
    // three tails straight after the header: page and command are tails, page unknown
    send_byte(8'h55, 1'b1);
    repeat (3) send_byte(8'hFF, 1'b1);
    // header byte inside a frame is plain text
    send_byte(8'h55, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h55, 1'b1);
    repeat (3) send_byte(8'hFF, 1'b1);
    // tail as command byte, then broken off by text, then the real close
    send_byte(8'h55, 1'b1);
    send_byte(8'h03, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    repeat (3) send_byte(8'hFF, 1'b1);
    // shortest frame with a known page: empty text
    send_byte(8'h55, 1'b1);
    send_byte(8'h02, 1'b1);
    send_byte(8'h7F, 1'b1);
    repeat (3) send_byte(8'hFF, 1'b1);
    settle();

    // phase 1: header at zero, tail inside the page range so tail-only frames emit
    load_markers(8'h00, 8'h02);
    send_byte(8'h00, 1'b1);
    repeat (3) send_byte(8'h02, 1'b1);
    while (work_bytes < 140) send_frame();
    settle();

    // phase 2: opposite extremes
    load_markers(8'hFF, 8'h00);
    while (work_bytes < 255) send_frame();
    settle();

    // phase 3: header and tail share one value
    load_markers(8'hA5, 8'hA5);
    while (work_bytes < 370) send_frame();
    settle();

    // phase 4: arbitrary markers
    load_markers(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
    while (work_bytes < 445) send_frame();

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
